// ===== rtl/core/tpan_pkg.sv =====
package tpan_pkg;

  // store and field sizes
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 16;
  localparam int WIDE_W     = 128;
  localparam int PC_W       = 6;
  localparam int DIV_W      = 45;
  localparam int DIV_CNT_W  = 6;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic CFG_CLOSED = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  // micro-op codes
  typedef enum logic [3:0] {
    OP_RD1, OP_RD2, OP_RD3, OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_SUB2,
    OP_CNEG, OP_MOVE, OP_FLIP, OP_ABS, OP_NORM, OP_SQRT, OP_DIV
  } op_t;

  // datapath working registers
  typedef enum logic [4:0] {
    R_X2, R_Y2, R_X3, R_Y3, R_CX, R_CY, R_D, R_E, R_S2, R_S3,
    R_NX, R_NY, R_T, R_U, R_WX, R_WY, R_SX, R_SY, R_PCX, R_PCY
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t a;
    reg_t b;
  } uword_t;

  typedef struct packed {
    logic       go;
    logic       emit;
    logic [1:0] code;
    uword_t     uw;
  } dp_cmd_t;

  typedef struct packed {
    logic fin;
    logic invalid;
    logic d_zero;
    logic e_zero;
    logic vec_zero;
  } dp_stat_t;

  // program branch points
  localparam logic [PC_W-1:0] PC_BR_D  = 6'd7;
  localparam logic [PC_W-1:0] PC_SEG_B = 6'd8;
  localparam logic [PC_W-1:0] PC_END_B = 6'd25;
  localparam logic [PC_W-1:0] PC_SEG_C = 6'd26;
  localparam logic [PC_W-1:0] PC_END_C = 6'd33;
  localparam logic [PC_W-1:0] PC_SEG_D = 6'd34;
  localparam logic [PC_W-1:0] PC_END_D = 6'd35;
  localparam logic [PC_W-1:0] PC_TAIL  = 6'd36;
  localparam logic [PC_W-1:0] PC_LAST  = 6'd43;

  // microprogram: fetch, circle fit (general / collinear / degenerate), normalize
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      6'd0:  u = '{OP_RD1,  R_T,  R_T,   R_T};
      6'd1:  u = '{OP_RD2,  R_T,  R_T,   R_T};
      6'd2:  u = '{OP_RD3,  R_T,  R_T,   R_T};
      6'd3:  u = '{OP_LOAD, R_T,  R_T,   R_T};
      6'd4:  u = '{OP_MUL,  R_T,  R_X2,  R_Y3};
      6'd5:  u = '{OP_MUL,  R_U,  R_X3,  R_Y2};
      6'd6:  u = '{OP_FLIP, R_T,  R_T,   R_U};
      6'd7:  u = '{OP_SUB2, R_D,  R_T,   R_U};
      6'd8:  u = '{OP_MUL,  R_T,  R_X2,  R_X2};
      6'd9:  u = '{OP_MUL,  R_U,  R_Y2,  R_Y2};
      6'd10: u = '{OP_ADD,  R_S2, R_T,   R_U};
      6'd11: u = '{OP_MUL,  R_T,  R_X3,  R_X3};
      6'd12: u = '{OP_MUL,  R_U,  R_Y3,  R_Y3};
      6'd13: u = '{OP_ADD,  R_S3, R_T,   R_U};
      6'd14: u = '{OP_MUL,  R_T,  R_Y3,  R_S2};
      6'd15: u = '{OP_MUL,  R_U,  R_Y2,  R_S3};
      6'd16: u = '{OP_SUB,  R_NX, R_T,   R_U};
      6'd17: u = '{OP_MUL,  R_T,  R_X2,  R_S3};
      6'd18: u = '{OP_MUL,  R_U,  R_X3,  R_S2};
      6'd19: u = '{OP_SUB,  R_NY, R_T,   R_U};
      6'd20: u = '{OP_MUL,  R_T,  R_CX,  R_D};
      6'd21: u = '{OP_SUB,  R_WX, R_T,   R_NX};
      6'd22: u = '{OP_MUL,  R_T,  R_CY,  R_D};
      6'd23: u = '{OP_SUB,  R_WY, R_T,   R_NY};
      6'd24: u = '{OP_CNEG, R_WX, R_WX,  R_D};
      6'd25: u = '{OP_CNEG, R_WY, R_WY,  R_D};
      6'd26: u = '{OP_MUL,  R_T,  R_X2,  R_SX};
      6'd27: u = '{OP_MUL,  R_U,  R_Y2,  R_SY};
      6'd28: u = '{OP_ADD,  R_U,  R_T,   R_U};
      6'd29: u = '{OP_MUL,  R_T,  R_PCX, R_E};
      6'd30: u = '{OP_SUB,  R_WX, R_T,   R_U};
      6'd31: u = '{OP_MUL,  R_WY, R_PCY, R_E};
      6'd32: u = '{OP_CNEG, R_WX, R_WX,  R_E};
      6'd33: u = '{OP_CNEG, R_WY, R_WY,  R_E};
      6'd34: u = '{OP_MOVE, R_WX, R_PCX, R_T};
      6'd35: u = '{OP_MOVE, R_WY, R_PCY, R_T};
      6'd36: u = '{OP_ABS,  R_T,  R_WX,  R_WY};
      6'd37: u = '{OP_NORM, R_T,  R_T,   R_U};
      6'd38: u = '{OP_MUL,  R_S2, R_T,   R_T};
      6'd39: u = '{OP_MUL,  R_S3, R_U,   R_U};
      6'd40: u = '{OP_ADD,  R_NX, R_S2,  R_S3};
      6'd41: u = '{OP_SQRT, R_NY, R_NX,  R_T};
      6'd42: u = '{OP_DIV,  R_WX, R_T,   R_NY};
      6'd43: u = '{OP_DIV,  R_WY, R_U,   R_NY};
      default: u = '{OP_MOVE, R_T, R_T, R_T};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/tpan_ctrl.sv =====
module tpan_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               req_type,
  input  tpan_pkg::dp_stat_t stat,
  output tpan_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_ISSUE  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                      state;
  logic [tpan_pkg::PC_W-1:0]   pc;
  logic [1:0]                  code;
  logic [tpan_pkg::PC_W-1:0]   pc_next;

  // branch after each finished micro-op
  always_comb begin
    case (pc)
      tpan_pkg::PC_BR_D: begin
        if (!stat.d_zero) pc_next = tpan_pkg::PC_SEG_B;
        else if (!stat.e_zero) pc_next = tpan_pkg::PC_SEG_C;
        else pc_next = tpan_pkg::PC_SEG_D;
      end
      tpan_pkg::PC_END_B, tpan_pkg::PC_END_C, tpan_pkg::PC_END_D:
        pc_next = tpan_pkg::PC_TAIL;
      default: pc_next = pc + 1'b1;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      code  <= tpan_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && req_type) state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.invalid) begin
            code  <= tpan_pkg::ST_INVALID;
            state <= S_RESULT;
          end else begin
            pc    <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (stat.fin) begin
            if (pc == tpan_pkg::PC_TAIL && stat.vec_zero) begin
              code  <= tpan_pkg::ST_ZERO;
              state <= S_RESULT;
            end else if (pc == tpan_pkg::PC_LAST) begin
              code  <= tpan_pkg::ST_OK;
              state <= S_RESULT;
            end else begin
              pc    <= pc_next;
              state <= S_ISSUE;
            end
          end
        end
        S_RESULT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.go   = (state == S_ISSUE);
  assign cmd.emit = (state == S_RESULT);
  assign cmd.code = code;
  assign cmd.uw   = tpan_pkg::ucode(pc);

endmodule

// ===== rtl/core/tpan_datapath.sv =====
module tpan_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             req_type,
  input  logic [tpan_pkg::ADDR_W-1:0]      point_index,
  input  logic signed [tpan_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tpan_pkg::COORD_W-1:0] coord_y,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [tpan_pkg::CNT_W-1:0]       cfg_data,
  input  tpan_pkg::dp_cmd_t                cmd,
  output tpan_pkg::dp_stat_t               stat,
  output logic                             done,
  output logic signed [tpan_pkg::NORM_W-1:0] normal_x,
  output logic signed [tpan_pkg::NORM_W-1:0] normal_y,
  output logic [1:0]                       status
);

  localparam logic [1:0] CP_FIRST = 2'd0;
  localparam logic [1:0] CP_MID   = 2'd1;
  localparam logic [1:0] CP_LAST  = 2'd2;

  // configuration
  logic                       closed_curve;
  logic [tpan_pkg::CNT_W-1:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_curve <= 1'b0;
      point_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpan_pkg::CFG_CLOSED: closed_curve <= cfg_data[0];
        tpan_pkg::CFG_COUNT:  point_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // neighbour selection for a query
  logic [tpan_pkg::CNT_W-1:0]  n_ext, cnt_m1;
  logic [tpan_pkg::ADDR_W-1:0] n_dec, n_inc, n_dec2;
  logic                        is_last, is_first, bad;
  logic [tpan_pkg::ADDR_W-1:0] j1, j2, j3;
  logic [1:0]                  jcp;

  always_comb begin
    n_ext    = {1'b0, point_index};
    cnt_m1   = point_count - 1'b1;
    n_dec    = point_index - 1'b1;
    n_dec2   = point_index - 2'd2;
    n_inc    = point_index + 1'b1;
    is_last  = (n_ext == cnt_m1);
    is_first = (point_index == '0);
    bad      = (point_count < 11'd3)
            || (point_count > tpan_pkg::CNT_W'(tpan_pkg::MAX_POINTS))
            || (n_ext >= point_count);
    j1  = n_dec;
    j2  = point_index;
    j3  = n_inc;
    jcp = CP_MID;
    if (closed_curve) begin
      if (is_first) j1 = cnt_m1[tpan_pkg::ADDR_W-1:0];
      if (is_last)  j3 = '0;
    end else if (is_last) begin
      j1  = n_dec2;
      j2  = n_dec;
      j3  = point_index;
      jcp = CP_LAST;
    end else if (is_first) begin
      j1  = '0;
      j2  = tpan_pkg::ADDR_W'(1);
      j3  = tpan_pkg::ADDR_W'(2);
      jcp = CP_FIRST;
    end
  end

  logic [tpan_pkg::ADDR_W-1:0] i1, i2, i3;
  logic [1:0]                  cp;
  logic                        invalid;

  always_ff @(posedge clk) begin
    if (accept && req_type) begin
      i1      <= j1;
      i2      <= j2;
      i3      <= j3;
      cp      <= jcp;
      invalid <= bad;
    end
  end

  // front store, x in the upper word
  logic [2*tpan_pkg::COORD_W-1:0] mem [tpan_pkg::MAX_POINTS];
  logic [2*tpan_pkg::COORD_W-1:0] mem_rd;
  logic [tpan_pkg::ADDR_W-1:0]    rd_addr;
  logic                           rd_en;
  logic                           act;
  tpan_pkg::uword_t               uw;

  assign uw = cmd.uw;

  always_ff @(posedge clk) begin
    if (accept && !req_type) mem[point_index] <= {coord_x, coord_y};
  end

  always_comb begin
    rd_en   = act && (uw.op == tpan_pkg::OP_RD1 || uw.op == tpan_pkg::OP_RD2
                      || uw.op == tpan_pkg::OP_RD3);
    case (uw.op)
      tpan_pkg::OP_RD1: rd_addr = i1;
      tpan_pkg::OP_RD2: rd_addr = i2;
      default:          rd_addr = i3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_rd <= mem[rd_addr];
  end

  // working registers
  logic [tpan_pkg::WIDE_W-1:0] x2, y2, x3, y3, cx, cy, d, e, s2, s3;
  logic [tpan_pkg::WIDE_W-1:0] nx, ny, t, u, wx, wy, sx, sy, pcx, pcy;
  logic signed [tpan_pkg::COORD_W-1:0] p1x, p1y, p2x, p2y, p3x, p3y;
  logic flip, nx_neg, ny_neg, vec_zero;

  function automatic logic [tpan_pkg::WIDE_W-1:0] sx32(
    input logic [tpan_pkg::COORD_W-1:0] v);
    return {{(tpan_pkg::WIDE_W-tpan_pkg::COORD_W){v[tpan_pkg::COORD_W-1]}}, v};
  endfunction

  function automatic logic [tpan_pkg::WIDE_W-1:0] rsel(
    input tpan_pkg::reg_t r,
    input logic [tpan_pkg::WIDE_W-1:0] vx2, vy2, vx3, vy3, vcx, vcy, vd, ve,
    input logic [tpan_pkg::WIDE_W-1:0] vs2, vs3, vnx, vny, vt, vu, vwx, vwy,
    input logic [tpan_pkg::WIDE_W-1:0] vsx, vsy, vpcx, vpcy);
    logic [tpan_pkg::WIDE_W-1:0] v;
    case (r)
      tpan_pkg::R_X2:  v = vx2;
      tpan_pkg::R_Y2:  v = vy2;
      tpan_pkg::R_X3:  v = vx3;
      tpan_pkg::R_Y3:  v = vy3;
      tpan_pkg::R_CX:  v = vcx;
      tpan_pkg::R_CY:  v = vcy;
      tpan_pkg::R_D:   v = vd;
      tpan_pkg::R_E:   v = ve;
      tpan_pkg::R_S2:  v = vs2;
      tpan_pkg::R_S3:  v = vs3;
      tpan_pkg::R_NX:  v = vnx;
      tpan_pkg::R_NY:  v = vny;
      tpan_pkg::R_T:   v = vt;
      tpan_pkg::R_U:   v = vu;
      tpan_pkg::R_WX:  v = vwx;
      tpan_pkg::R_WY:  v = vwy;
      tpan_pkg::R_SX:  v = vsx;
      tpan_pkg::R_SY:  v = vsy;
      tpan_pkg::R_PCX: v = vpcx;
      tpan_pkg::R_PCY: v = vpcy;
      default:         v = vt;
    endcase
    return v;
  endfunction

  logic [tpan_pkg::WIDE_W-1:0] src_a, src_b;

  assign src_a = rsel(uw.a, x2, y2, x3, y3, cx, cy, d, e, s2, s3, nx, ny, t, u,
                      wx, wy, sx, sy, pcx, pcy);
  assign src_b = rsel(uw.b, x2, y2, x3, y3, cx, cy, d, e, s2, s3, nx, ny, t, u,
                      wx, wy, sx, sy, pcx, pcy);

  // shift-add multiplier, root and divider state
  logic [tpan_pkg::WIDE_W-1:0]  mul_a, mul_b, mul_acc;
  logic                         mul_neg;
  logic [63:0]                  sq_n, sq_res, sq_bit, sq_sum;
  logic [tpan_pkg::DIV_W-1:0]   dv_num;
  logic [31:0]                  dv_rem, dv_m;
  logic [tpan_pkg::NORM_W-1:0]  dv_q;
  logic [tpan_pkg::DIV_CNT_W-1:0] dv_cnt;
  logic [32:0]                  dv_trial;
  logic [tpan_pkg::WIDE_W-1:0]  nor_or;

  assign sq_sum   = sq_res + sq_bit;
  assign dv_trial = {dv_rem, dv_num[tpan_pkg::DIV_W-1]};
  assign nor_or   = t | u;

  // finish and write-back for single-destination ops
  logic                        finish, wr_en;
  logic [tpan_pkg::WIDE_W-1:0] wr_data;

  always_comb begin
    finish  = 1'b1;
    wr_en   = 1'b0;
    wr_data = src_a;
    case (uw.op)
      tpan_pkg::OP_MUL: begin
        finish  = (mul_b == '0);
        wr_en   = finish;
        wr_data = mul_neg ? -mul_acc : mul_acc;
      end
      tpan_pkg::OP_ADD: begin
        wr_en   = 1'b1;
        wr_data = src_a + src_b;
      end
      tpan_pkg::OP_SUB: begin
        wr_en   = 1'b1;
        wr_data = src_a - src_b;
      end
      tpan_pkg::OP_SUB2: begin
        wr_en   = 1'b1;
        wr_data = (src_a - src_b) << 1;
      end
      tpan_pkg::OP_CNEG: begin
        wr_en   = 1'b1;
        wr_data = src_b[tpan_pkg::WIDE_W-1] ? -src_a : src_a;
      end
      tpan_pkg::OP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = src_a;
      end
      tpan_pkg::OP_NORM: begin
        finish = !(|nor_or[tpan_pkg::WIDE_W-1:30]) && nor_or[29];
      end
      tpan_pkg::OP_SQRT: begin
        finish  = (sq_bit == '0);
        wr_en   = finish;
        wr_data = tpan_pkg::WIDE_W'(sq_res);
      end
      tpan_pkg::OP_DIV: begin
        finish  = (dv_cnt == '0);
        wr_en   = finish;
        wr_data = tpan_pkg::WIDE_W'(dv_q);
      end
      default: ;
    endcase
  end

  // control flags
  logic fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= act && finish;
      if (cmd.go) act <= 1'b1;
      else if (finish) act <= 1'b0;
    end
  end

  // iterative units and register file
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      case (uw.op)
        tpan_pkg::OP_MUL: begin
          mul_a   <= src_a;
          mul_b   <= src_b[tpan_pkg::WIDE_W-1] ? -src_b : src_b;
          mul_neg <= src_b[tpan_pkg::WIDE_W-1];
          mul_acc <= '0;
        end
        tpan_pkg::OP_SQRT: begin
          sq_n   <= src_a[63:0];
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
        end
        tpan_pkg::OP_DIV: begin
          dv_num <= {src_a[30:0], 14'd0} + tpan_pkg::DIV_W'(src_b[31:1]);
          dv_m   <= src_b[31:0];
          dv_rem <= '0;
          dv_q   <= '0;
          dv_cnt <= tpan_pkg::DIV_CNT_W'(tpan_pkg::DIV_W);
        end
        default: ;
      endcase
    end else if (act) begin
      case (uw.op)
        tpan_pkg::OP_RD2: {p1x, p1y} <= mem_rd;
        tpan_pkg::OP_RD3: {p2x, p2y} <= mem_rd;
        tpan_pkg::OP_LOAD: begin
          {p3x, p3y} <= mem_rd;
          x2  <= sx32(p2x) - sx32(p1x);
          y2  <= sx32(p2y) - sx32(p1y);
          x3  <= sx32(mem_rd[63:32]) - sx32(p1x);
          y3  <= sx32(mem_rd[31:0]) - sx32(p1y);
          e   <= (sx32(p2x) - sx32(p1x)) << 1;
          sx  <= sx32(p2x) + sx32(p1x);
          sy  <= sx32(p2y) + sx32(p1y);
          case (cp)
            CP_FIRST: begin
              pcx <= sx32(p1x);
              pcy <= sx32(p1y);
              cx  <= '0;
              cy  <= '0;
            end
            CP_LAST: begin
              pcx <= sx32(mem_rd[63:32]);
              pcy <= sx32(mem_rd[31:0]);
              cx  <= sx32(mem_rd[63:32]) - sx32(p1x);
              cy  <= sx32(mem_rd[31:0]) - sx32(p1y);
            end
            default: begin
              pcx <= sx32(p2x);
              pcy <= sx32(p2y);
              cx  <= sx32(p2x) - sx32(p1x);
              cy  <= sx32(p2y) - sx32(p1y);
            end
          endcase
        end
        tpan_pkg::OP_FLIP: begin
          // side of the chord p1-p3 on which p2 lies
          if (y3 != '0) begin
            if (x3 != '0) begin
              if (!x3[tpan_pkg::WIDE_W-1]) flip <= (u - t) >> (tpan_pkg::WIDE_W-1) != '0;
              else                         flip <= (t - u) >> (tpan_pkg::WIDE_W-1) != '0;
            end else begin
              flip <= p2x < p3x;
            end
          end else begin
            flip <= p2y < p3y;
          end
        end
        tpan_pkg::OP_MUL: begin
          if (mul_b != '0) begin
            if (mul_b[0]) mul_acc <= mul_acc + mul_a;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end
        end
        tpan_pkg::OP_ABS: begin
          t        <= wx[tpan_pkg::WIDE_W-1] ? -wx : wx;
          u        <= wy[tpan_pkg::WIDE_W-1] ? -wy : wy;
          nx_neg   <= wx[tpan_pkg::WIDE_W-1] ^ flip;
          ny_neg   <= wy[tpan_pkg::WIDE_W-1] ^ flip;
          vec_zero <= (wx == '0) && (wy == '0);
        end
        tpan_pkg::OP_NORM: begin
          // one bit a cycle until the larger magnitude tops out at bit 29
          if (|nor_or[tpan_pkg::WIDE_W-1:30]) begin
            t <= t >> 1;
            u <= u >> 1;
          end else if (!nor_or[29]) begin
            t <= t << 1;
            u <= u << 1;
          end
        end
        tpan_pkg::OP_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_n >= sq_sum) begin
              sq_n   <= sq_n - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        tpan_pkg::OP_DIV: begin
          if (dv_cnt != '0) begin
            if (dv_trial >= {1'b0, dv_m}) begin
              dv_rem <= 32'(dv_trial - {1'b0, dv_m});
              dv_q   <= {dv_q[tpan_pkg::NORM_W-2:0], 1'b1};
            end else begin
              dv_rem <= dv_trial[31:0];
              dv_q   <= {dv_q[tpan_pkg::NORM_W-2:0], 1'b0};
            end
            dv_num <= dv_num << 1;
            dv_cnt <= dv_cnt - 1'b1;
          end
        end
        default: ;
      endcase
      if (wr_en) begin
        case (uw.dst)
          tpan_pkg::R_X2:  x2  <= wr_data;
          tpan_pkg::R_Y2:  y2  <= wr_data;
          tpan_pkg::R_X3:  x3  <= wr_data;
          tpan_pkg::R_Y3:  y3  <= wr_data;
          tpan_pkg::R_CX:  cx  <= wr_data;
          tpan_pkg::R_CY:  cy  <= wr_data;
          tpan_pkg::R_D:   d   <= wr_data;
          tpan_pkg::R_E:   e   <= wr_data;
          tpan_pkg::R_S2:  s2  <= wr_data;
          tpan_pkg::R_S3:  s3  <= wr_data;
          tpan_pkg::R_NX:  nx  <= wr_data;
          tpan_pkg::R_NY:  ny  <= wr_data;
          tpan_pkg::R_T:   t   <= wr_data;
          tpan_pkg::R_U:   u   <= wr_data;
          tpan_pkg::R_WX:  wx  <= wr_data;
          tpan_pkg::R_WY:  wy  <= wr_data;
          tpan_pkg::R_SX:  sx  <= wr_data;
          tpan_pkg::R_SY:  sy  <= wr_data;
          tpan_pkg::R_PCX: pcx <= wr_data;
          tpan_pkg::R_PCY: pcy <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // status to the controller
  assign stat.fin      = fin;
  assign stat.invalid  = invalid;
  assign stat.d_zero   = (d == '0);
  assign stat.e_zero   = (e == '0);
  assign stat.vec_zero = vec_zero;

  // result word
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.code;
      if (cmd.code == tpan_pkg::ST_OK) begin
        normal_x <= nx_neg ? -wx[tpan_pkg::NORM_W-1:0] : wx[tpan_pkg::NORM_W-1:0];
        normal_y <= ny_neg ? -wy[tpan_pkg::NORM_W-1:0] : wy[tpan_pkg::NORM_W-1:0];
      end else begin
        normal_x <= '0;
        normal_y <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/three_point_arc_normal_top.sv =====
// Channel   Ports                                         Handshake
// ------    --------------------------------------------  ---------------------------
// request   req_type, point_index, coord_x, coord_y        taken when start && !busy
// result    normal_x, normal_y, status                     one-cycle done strobe
// config    cfg_we, cfg_addr, cfg_data                     written when cfg_we
//
// A point write leaves busy low. A rejected query (bad index or count) returns its
// word without running the microprogram. A valid query runs the fetch, one fit
// branch and the tail of the 44 microprogram steps, a zero-length one only the
// tail's first step; a full normal's run time is set by the shift-add multiplier
// (one bit a cycle), the one-bit-a-cycle normalizer and bit-serial root and divider.
// Reset is synchronous and clears the control state and the config registers;
// the store contents stay as they are. The receiver cannot stall.
module three_point_arc_normal_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic [tpan_pkg::ADDR_W-1:0]         point_index,
  input  logic signed [tpan_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tpan_pkg::COORD_W-1:0] coord_y,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [tpan_pkg::CNT_W-1:0]          cfg_data,
  output logic                                done,
  output logic signed [tpan_pkg::NORM_W-1:0]  normal_x,
  output logic signed [tpan_pkg::NORM_W-1:0]  normal_y,
  output logic [1:0]                          status
);

  tpan_pkg::dp_cmd_t  cmd;
  tpan_pkg::dp_stat_t stat;

  tpan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tpan_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .status      (status)
  );

  // a query never returns two words in a row
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // a taken query keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy)
    else $error("query taken without going busy");

  // flagged results carry a zero normal
  assert property (@(posedge clk) disable iff (rst)
    (done && status != tpan_pkg::ST_OK) |-> (normal_x == '0 && normal_y == '0))
    else $error("nonzero normal on a flagged result");

  // only defined status codes are reported
  assert property (@(posedge clk) disable iff (rst)
    done |-> (status == tpan_pkg::ST_OK || status == tpan_pkg::ST_ZERO
              || status == tpan_pkg::ST_INVALID))
    else $error("undefined status code");

endmodule

// ===== tb/tb_three_point_arc_normal_top.sv =====
module tb_three_point_arc_normal_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpan_pkg::*;

  localparam bit REQ_WRITE = 1'b0;
  localparam bit REQ_QUERY = 1'b1;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEM_TARGET = 1700;

  typedef logic signed [127:0] s128_t;
  typedef logic [127:0] u128_t;

  typedef struct {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic [1:0]               st;
  } normal_word_t;

  // Scoreboard: mirror of the front store and config, plus expected-normal queue
  class arc_scoreboard;
    logic signed [COORD_W-1:0] front_x[MAX_POINTS];
    logic signed [COORD_W-1:0] front_y[MAX_POINTS];
    bit                        closed;
    int unsigned               count;
    normal_word_t              normals_due[$];
    int                        errors;
    int                        n_writes, n_ok, n_zero, n_invalid;

    function void set_reg(logic addr, logic [CNT_W-1:0] data);
      if (addr == CFG_CLOSED) closed = data[0];
      else count = data;
    endfunction

    function int pending();
      return normals_due.size();
    endfunction

    static function int bitlen(u128_t v);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
      return n;
    endfunction

    static function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    static function logic [15:0] scale_q14(logic [63:0] a, logic [63:0] m, bit neg);
      logic [63:0] v;
      v = ((a << 14) + (m >> 1)) / m;
      return neg ? 16'(-v) : v[15:0];
    endfunction

    // normal at index n from the circle through it and its neighbors
    function normal_word_t arc_normal(int unsigned n);
      normal_word_t r;
      int unsigned i1, i2, i3, cp;
      s128_t p1x, p1y, p2x, p2y, p3x, p3y, pcx, pcy;
      s128_t x2, y2, x3, y3, d, s2, s3, nxw, nyw, wx, wy, e, k, lhs, rhs;
      u128_t mx, my;
      bit flip, nxneg, nyneg;
      int bl;
      logic [63:0] ax, ay, m;
      r.nx = 0; r.ny = 0; r.st = ST_INVALID;
      if (count < 3 || count > MAX_POINTS || n >= count) return r;
      cp = 2;
      if (closed) begin
        i1 = (n == 0) ? count - 1 : n - 1;
        i2 = n;
        i3 = (n == count - 1) ? 0 : n + 1;
      end else if (n == count - 1) begin
        i1 = n - 2; i2 = n - 1; i3 = n; cp = 3;
      end else if (n == 0) begin
        i1 = 0; i2 = 1; i3 = 2; cp = 1;
      end else begin
        i1 = n - 1; i2 = n; i3 = n + 1;
      end
      p1x = front_x[i1]; p1y = front_y[i1];
      p2x = front_x[i2]; p2y = front_y[i2];
      p3x = front_x[i3]; p3y = front_y[i3];
      pcx = (cp == 1) ? p1x : (cp == 2) ? p2x : p3x;
      pcy = (cp == 1) ? p1y : (cp == 2) ? p2y : p3y;
      x2 = p2x - p1x; y2 = p2y - p1y; x3 = p3x - p1x; y3 = p3y - p1y;
      d = 2 * (x2 * y3 - x3 * y2);
      if (d != 0) begin
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        nxw = y3 * s2 - y2 * s3;
        nyw = x2 * s3 - x3 * s2;
        wx = (pcx - p1x) * d - nxw;
        wy = (pcy - p1y) * d - nyw;
        if (d < 0) begin wx = -wx; wy = -wy; end
      end else begin
        // collinear: center taken on the x axis
        e = 2 * x2;
        if (e != 0) begin
          k = x2 * (p2x + p1x) + y2 * (p2y + p1y);
          wx = pcx * e - k;
          wy = pcy * e;
          if (e < 0) begin wx = -wx; wy = -wy; end
        end else begin
          wx = pcx; wy = pcy;
        end
      end
      // side of chord p1-p3 that p2 lies on
      if (y3 != 0) begin
        if (x3 != 0) begin
          lhs = y3 * x2;
          rhs = y2 * x3;
          flip = (x3 > 0) ? (rhs < lhs) : (lhs < rhs);
        end else flip = p2x < p3x;
      end else flip = p2y < p3y;
      if (wx == 0 && wy == 0) begin
        r.st = ST_ZERO;
        return r;
      end
      nxneg = (wx < 0) != flip;
      nyneg = (wy < 0) != flip;
      mx = (wx < 0) ? -wx : wx;
      my = (wy < 0) ? -wy : wy;
      bl = bitlen(mx) > bitlen(my) ? bitlen(mx) : bitlen(my);
      if (bl > 30) begin
        ax = 64'(mx >> (bl - 30)); ay = 64'(my >> (bl - 30));
      end else begin
        ax = mx[63:0] << (30 - bl); ay = my[63:0] << (30 - bl);
      end
      m = isqrt(ax * ax + ay * ay);
      r.nx = (ax == 0) ? 16'sd0 : scale_q14(ax, m, nxneg);
      r.ny = (ay == 0) ? 16'sd0 : scale_q14(ay, m, nyneg);
      r.st = ST_OK;
      return r;
    endfunction

    function void note(logic rt, logic [ADDR_W-1:0] idx,
                       logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      normal_word_t w;
      if (rt == REQ_WRITE) begin
        front_x[idx] = x;
        front_y[idx] = y;
        n_writes++;
      end else begin
        w = arc_normal(idx);
        normals_due.push_back(w);
        if (w.st == ST_OK) n_ok++;
        else if (w.st == ST_ZERO) n_zero++;
        else n_invalid++;
      end
    endfunction

    function void check(logic signed [NORM_W-1:0] nx, logic signed [NORM_W-1:0] ny,
                        logic [1:0] st);
      normal_word_t w;
      if (normals_due.size() == 0) begin
        $error("unexpected result word: normal_x=%0d normal_y=%0d status=%0d", nx, ny, st);
        errors++;
        return;
      end
      w = normals_due.pop_front();
      if (st !== w.st) begin
        $error("status: expected %0d, actual %0d", w.st, st);
        errors++;
      end
      if (nx !== w.nx) begin
        $error("normal_x: expected %0d, actual %0d", w.nx, nx);
        errors++;
      end
      if (ny !== w.ny) begin
        $error("normal_y: expected %0d, actual %0d", w.ny, ny);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      req_type = 1'b0;
  logic [ADDR_W-1:0]         point_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_addr = 1'b0;
  logic [CNT_W-1:0]          cfg_data = '0;
  logic                      done;
  logic signed [NORM_W-1:0]  normal_x, normal_y;
  logic [1:0]                status;

  arc_scoreboard sb = new();
  bit            written[MAX_POINTS];
  int            sent;
  int            idle_cycles;

  three_point_arc_normal_top dut (.*);

  always #5 clk = ~clk;

  // monitor: record accepted words, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note(req_type, point_index, coord_x, coord_y);
      if (done) sb.check(normal_x, normal_y, status);
      if ((start && !busy) || done) idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_three_point_arc_normal_top: errors");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // drive one word and hold it until the block takes it
  task automatic send_word(logic rt, logic [ADDR_W-1:0] idx,
                           logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    start <= 1'b1;
    req_type <= rt;
    point_index <= idx;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rt == REQ_WRITE) written[idx] = 1'b1;
    sent++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [CNT_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 16) - 8;          // tiny: collinear and repeats
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return 32'($urandom);
      3: return $urandom_range(0, 2000) - 1000;
      default: return 32'($signed($urandom) >>> $urandom_range(8, 24));
    endcase
  endfunction

  // make sure every point a valid query can read has been written
  task automatic fill_front();
    for (int i = 0; i < sb.count && i < MAX_POINTS; i++)
      if (!written[i]) send_word(REQ_WRITE, i, rand_coord(), rand_coord());
  endtask

  task automatic random_phase(bit cl, int unsigned cnt, int items);
    int burst;
    int unsigned lim;
    logic [ADDR_W-1:0] idx;
    write_reg(CFG_CLOSED, cl);
    write_reg(CFG_COUNT, cnt);
    fill_front();
    lim = (cnt >= 1 && cnt <= MAX_POINTS) ? cnt : MAX_POINTS;
    while (items > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        case ($urandom_range(0, 3))
          0: idx = 0;
          1: idx = lim - 1;
          default: idx = $urandom_range(0, lim - 1);
        endcase
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, MAX_POINTS - 1);
        if ($urandom_range(0, 9) < 3) send_word(REQ_QUERY, idx, rand_coord(), rand_coord());
        else if (idx < lim || cnt > MAX_POINTS || cnt < 3 || idx >= cnt)
          send_word(REQ_WRITE, idx, rand_coord(), rand_coord());
        items--;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    int unsigned cnt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: minimum count, open-curve ends, invalid queries, extremes
    write_reg(CFG_CLOSED, 1'b0);
    write_reg(CFG_COUNT, 3);
    send_word(REQ_WRITE, 0, 32'sh0000_0000, 32'sh0000_0100);
    send_word(REQ_WRITE, 1, 32'sh0000_0100, 32'sh0000_0000);
    send_word(REQ_WRITE, 2, 32'sh0000_0000, -32'sh0000_0100);
    send_word(REQ_QUERY, 0, 0, 0);
    send_word(REQ_QUERY, 1, 0, 0);
    send_word(REQ_QUERY, 2, 0, 0);
    send_word(REQ_QUERY, 3, 0, 0);
    send_word(REQ_QUERY, 1023, 32'sh7FFFFFFF, 32'sh80000000);
    send_word(REQ_WRITE, 1023, 32'sh7FFFFFFF, 32'sh80000000);
    // a new third point, then vertical collinear, then all coincident
    send_word(REQ_WRITE, 2, 32'sh0000_0200, 32'sh0000_fe00);
    send_word(REQ_QUERY, 1, 0, 0);
    send_word(REQ_WRITE, 0, 32'sh0000_0100, 32'sh0000_0300);
    send_word(REQ_WRITE, 2, 32'sh0000_0100, -32'sh0000_0300);
    send_word(REQ_QUERY, 1, 0, 0);
    send_word(REQ_WRITE, 0, 32'sh0, 32'sh0);
    send_word(REQ_WRITE, 1, 32'sh0, 32'sh0);
    send_word(REQ_WRITE, 2, 32'sh0, 32'sh0);
    send_word(REQ_QUERY, 2, 0, 0);
    send_word(REQ_WRITE, 0, 32'sh80000000, 32'sh7FFFFFFF);
    send_word(REQ_WRITE, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_word(REQ_WRITE, 2, 32'sh80000000, 32'sh80000000);
    write_reg(CFG_CLOSED, 1'b1);
    send_word(REQ_QUERY, 0, 0, 0);
    send_word(REQ_QUERY, 2, 0, 0);
    write_reg(CFG_COUNT, 0);
    send_word(REQ_QUERY, 0, 0, 0);

    // random phases over a spread of settings, extremes included
    random_phase(1'b0, 1024, 120);
    random_phase(1'b1, 1024, 120);
    random_phase(1'b1, 2047, 40);
    random_phase(1'b0, 2, 40);
    random_phase(1'b1, 3, 80);
    while (sent < ITEM_TARGET) begin
      cnt = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(3, 40);
      random_phase($urandom_range(0, 1), cnt, 100);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d point writes, %0d normals, %0d zero-length, %0d invalid",
             sent, sb.n_writes, sb.n_ok, sb.n_zero, sb.n_invalid);
    $display("open and closed curves, counts 0 to 2047, full-range and degenerate fronts");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_three_point_arc_normal_top: clean");
    end else begin
      $display("tb_three_point_arc_normal_top: errors");
    end
    $finish;
  end

endmodule
